[sv/qvr_pkg.sv]
// Package for the quaternion vector rotator: widths, shared types and
// register indexes. Depends on nothing; every other file imports it.
`default_nettype none

package qvr_pkg;

    // Component width and quaternion fraction bits.
    localparam int COMP_W = 16;
    localparam int FRAC_W = 14;

    // First product q * (0,v): three exact products summed, then rounded.
    localparam int PRD1_W = 2 * COMP_W;
    localparam int SUM1_W = PRD1_W + 2;
    localparam int PART_W = SUM1_W - FRAC_W;

    // Second product p * conj(q): four exact products summed, then rounded.
    localparam int PRD2_W = PART_W + COMP_W;
    localparam int SUM2_W = PRD2_W + 2;
    localparam int RND2_W = SUM2_W - FRAC_W;

    localparam int CFG_IDX_W = 2;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [PART_W-1:0] part_t;

    typedef struct packed {
        comp_t w;
        comp_t i;
        comp_t j;
        comp_t k;
    } quat_t;

    // Load enables for the two register stages inside one product unit.
    typedef struct packed {
        logic prod;
        logic sum;
    } stage_en_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_I = 2'd1,
        REG_QUAT_J = 2'd2,
        REG_QUAT_K = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

[sv/qvr_first.sv]
// First Hamilton product p = q * (0, v), two register stages: products, then
// rounded sums. Depends on qvr_pkg.
`default_nettype none

module qvr_first
    import qvr_pkg::*;
(
    input  wire logic      clk,
    input  wire stage_en_t en,
    input  wire quat_t     quat,
    input  wire comp_t     vec_x,
    input  wire comp_t     vec_y,
    input  wire comp_t     vec_z,
    output part_t          part_w,
    output part_t          part_i,
    output part_t          part_j,
    output part_t          part_k
);

    typedef logic signed [PRD1_W-1:0] prd_t;
    typedef logic signed [SUM1_W-1:0] sum_t;

    localparam sum_t RND = sum_t'(1) <<< (FRAC_W - 1);

    comp_t qw, qi, qj, qk;

    prd_t qix_reg, qjy_reg, qkz_reg, qwx_reg, qjz_reg, qky_reg;
    prd_t qwy_reg, qkx_reg, qiz_reg, qwz_reg, qiy_reg, qjx_reg;

    part_t pw_reg, pi_reg, pj_reg, pk_reg;

    // Round to nearest, ties up, and drop the fraction bits.
    function automatic part_t round_sum(input sum_t s);
        sum_t r;
        r = s + RND;
        return r[SUM1_W-1:FRAC_W];
    endfunction

    assign qw = quat.w;
    assign qi = quat.i;
    assign qj = quat.j;
    assign qk = quat.k;

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            qix_reg <= qi * vec_x;
            qjy_reg <= qj * vec_y;
            qkz_reg <= qk * vec_z;
            qwx_reg <= qw * vec_x;
            qjz_reg <= qj * vec_z;
            qky_reg <= qk * vec_y;
            qwy_reg <= qw * vec_y;
            qkx_reg <= qk * vec_x;
            qiz_reg <= qi * vec_z;
            qwz_reg <= qw * vec_z;
            qiy_reg <= qi * vec_y;
            qjx_reg <= qj * vec_x;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            pw_reg <= round_sum(-sum_t'(qix_reg) - sum_t'(qjy_reg) - sum_t'(qkz_reg));
            pi_reg <= round_sum(sum_t'(qwx_reg) + sum_t'(qjz_reg) - sum_t'(qky_reg));
            pj_reg <= round_sum(sum_t'(qwy_reg) + sum_t'(qkx_reg) - sum_t'(qiz_reg));
            pk_reg <= round_sum(sum_t'(qwz_reg) + sum_t'(qiy_reg) - sum_t'(qjx_reg));
        end
    end

    assign part_w = pw_reg;
    assign part_i = pi_reg;
    assign part_j = pj_reg;
    assign part_k = pk_reg;

endmodule

`default_nettype wire

[sv/qvr_second.sv]
// Second Hamilton product p * conj(q), vector part only, with rounding and
// saturation; the sum stage is the block's output register. Depends on qvr_pkg.
`default_nettype none

module qvr_second
    import qvr_pkg::*;
(
    input  wire logic      clk,
    input  wire stage_en_t en,
    input  wire quat_t     quat,
    input  wire part_t     part_w,
    input  wire part_t     part_i,
    input  wire part_t     part_j,
    input  wire part_t     part_k,
    output comp_t          rot_x,
    output comp_t          rot_y,
    output comp_t          rot_z,
    output logic           clipped
);

    typedef logic signed [PRD2_W-1:0] prd_t;
    typedef logic signed [SUM2_W-1:0] sum_t;
    typedef logic signed [RND2_W-1:0] rnd_t;

    localparam sum_t  RND     = sum_t'(1) <<< (FRAC_W - 1);
    localparam comp_t SAT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam comp_t SAT_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    comp_t qw, qi, qj, qk;

    prd_t iw_reg, wi_reg, jk_reg, kj_reg;
    prd_t jw_reg, wj_reg, ki_reg, ik_reg;
    prd_t kw_reg, wk_reg, ij_reg, ji_reg;

    rnd_t  rx, ry, rz;
    comp_t sx, sy, sz;
    logic  hx, hy, hz;

    comp_t rot_x_reg, rot_y_reg, rot_z_reg;
    logic  clipped_reg;

    function automatic rnd_t round_sum(input sum_t s);
        sum_t r;
        r = s + RND;
        return r[SUM2_W-1:FRAC_W];
    endfunction

    // High when the value does not fit in a component.
    function automatic logic over(input rnd_t r);
        return (r[RND2_W-1:COMP_W-1] != '0) && (r[RND2_W-1:COMP_W-1] != '1);
    endfunction

    function automatic comp_t clamp(input rnd_t r);
        if (!over(r))
            return r[COMP_W-1:0];
        else if (r[RND2_W-1])
            return SAT_MIN;
        else
            return SAT_MAX;
    endfunction

    assign qw = quat.w;
    assign qi = quat.i;
    assign qj = quat.j;
    assign qk = quat.k;

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            iw_reg <= part_i * qw;
            wi_reg <= part_w * qi;
            jk_reg <= part_j * qk;
            kj_reg <= part_k * qj;
            jw_reg <= part_j * qw;
            wj_reg <= part_w * qj;
            ki_reg <= part_k * qi;
            ik_reg <= part_i * qk;
            kw_reg <= part_k * qw;
            wk_reg <= part_w * qk;
            ij_reg <= part_i * qj;
            ji_reg <= part_j * qi;
        end
    end

    always_comb
    begin
        rx = round_sum(sum_t'(iw_reg) - sum_t'(wi_reg) - sum_t'(jk_reg) + sum_t'(kj_reg));
        ry = round_sum(sum_t'(jw_reg) - sum_t'(wj_reg) - sum_t'(ki_reg) + sum_t'(ik_reg));
        rz = round_sum(sum_t'(kw_reg) - sum_t'(wk_reg) - sum_t'(ij_reg) + sum_t'(ji_reg));
        sx = clamp(rx);
        sy = clamp(ry);
        sz = clamp(rz);
        hx = over(rx);
        hy = over(ry);
        hz = over(rz);
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            rot_x_reg   <= sx;
            rot_y_reg   <= sy;
            rot_z_reg   <= sz;
            clipped_reg <= hx | hy | hz;
        end
    end

    assign rot_x   = rot_x_reg;
    assign rot_y   = rot_y_reg;
    assign rot_z   = rot_z_reg;
    assign clipped = clipped_reg;

endmodule

`default_nettype wire

[sv/quaternion_vector_rotate.sv]
// Quaternion vector rotator, top level: configuration registers, pipeline
// valid bits and flow control. Depends on qvr_pkg, qvr_first, qvr_second.
//
// Usage:
//   Write the quaternion (signed Q1.14 parts w, i, j, k) through cfg_we,
//   cfg_index and cfg_data while no vector is in flight. Stream vectors on
//   the input channel (in_valid / in_stall); a transfer happens on a clock
//   edge with in_valid high and in_stall low. Each vector v comes back as
//   the vector part of q * (0,v) * conj(q), rounded and saturated, on the
//   output channel (out_valid / out_stall), with clipped set if any
//   component overflowed and was saturated.
// Timing:
//   Four register stages: stage-one products, stage-one rounded sums,
//   stage-two products, stage-two sums into the output register. A vector
//   passes through the stages in that order into the output register;
//   one vector is taken every cycle while the output is not stalled,
//   since each stage advances whenever its successor does.
// Reset:
//   Clears all valid bits and loads the identity quaternion (w = 1.0).
// Stall:
//   A stalled output holds its result; empty stages behind it keep filling,
//   and in_stall rises only once every stage holds a vector.
`default_nettype none

module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire comp_t                cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire comp_t                vec_x,
    input  wire comp_t                vec_y,
    input  wire comp_t                vec_z,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output comp_t                     rot_x,
    output comp_t                     rot_y,
    output comp_t                     rot_z,
    output logic                      clipped
);

    localparam comp_t QUAT_ONE = comp_t'(1) <<< FRAC_W;

    quat_t quat_reg;

    // Valid bit of each stage: first products, first sums, second
    // products, output register.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    stage_en_t en_first, en_second;
    part_t     part_w, part_i, part_j, part_k;

    // Configuration writes: a plain indexed register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.w <= QUAT_ONE;
            quat_reg.i <= '0;
            quat_reg.j <= '0;
            quat_reg.k <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_QUAT_W: quat_reg.w <= cfg_data;
                REG_QUAT_I: quat_reg.i <= cfg_data;
                REG_QUAT_J: quat_reg.j <= cfg_data;
                REG_QUAT_K: quat_reg.k <= cfg_data;
                default:    quat_reg   <= quat_reg;
            endcase
        end
    end

    // A stage advances when it is empty or its successor advances, so
    // bubbles collapse behind a stalled output.
    assign adv4 = !v4_reg || !out_stall;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    // Load payload only when a valid item moves in; otherwise hold.
    assign en_first.prod  = adv1 && in_valid;
    assign en_first.sum   = adv2 && v1_reg;
    assign en_second.prod = adv3 && v2_reg;
    assign en_second.sum  = adv4 && v3_reg;

    qvr_first u_first (
        .clk    (clk),
        .en     (en_first),
        .quat   (quat_reg),
        .vec_x  (vec_x),
        .vec_y  (vec_y),
        .vec_z  (vec_z),
        .part_w (part_w),
        .part_i (part_i),
        .part_j (part_j),
        .part_k (part_k)
    );

    qvr_second u_second (
        .clk     (clk),
        .en      (en_second),
        .quat    (quat_reg),
        .part_w  (part_w),
        .part_i  (part_i),
        .part_j  (part_j),
        .part_k  (part_k),
        .rot_x   (rot_x),
        .rot_y   (rot_y),
        .rot_z   (rot_z),
        .clipped (clipped)
    );

    assign out_valid = v4_reg;

endmodule

`default_nettype wire

[sv/qvr_checker.sv]
// Port-level checks for the quaternion vector rotator, bound to the top
// level. Depends on qvr_pkg and quaternion_vector_rotate.
`default_nettype none

module qvr_checker
    import qvr_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  in_valid,
    input wire logic  in_stall,
    input wire logic  out_valid,
    input wire logic  out_stall,
    input wire comp_t rot_x,
    input wire comp_t rot_y,
    input wire comp_t rot_z,
    input wire logic  clipped
);

    localparam comp_t SAT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam comp_t SAT_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    // A waiting result holds until the transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rot_x) && $stable(rot_y)
            && $stable(rot_z) && $stable(clipped))
        else $error("output changed while stalled");

    // Input stalls only while a valid output is stalled.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in the pipeline");

    // Without output stalls a transferred vector reaches the output as a valid result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
            |=> out_valid)
        else $error("result missing four cycles after transfer");

    // The clip flag needs a component at a bound.
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> rot_x == SAT_MAX || rot_x == SAT_MIN
            || rot_y == SAT_MAX || rot_y == SAT_MIN
            || rot_z == SAT_MAX || rot_z == SAT_MIN)
        else $error("clipped set with no saturated component");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .clipped   (clipped)
);

`default_nettype wire
